FILE: design/button_debounce_press_classifier_assert.svh
// Assertion macros shared by the button classifier modules
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_ASSERT_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define BDPC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define BDPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/bdpc_pkg.sv
// Types, codes and reset values for the button debounce and press classifier
package bdpc_pkg;

	localparam int unsigned COUNTER_WIDTH_DEF = 16;
	localparam int unsigned TH_W              = 16;
	localparam int unsigned IDX_W             = 3;

	typedef enum logic [3:0] {
		EV_PRESS      = 4'd0,
		EV_RELEASE    = 4'd1,
		EV_SHORT      = 4'd2,
		EV_LONG_START = 4'd3,
		EV_REPEAT     = 4'd4,
		EV_LONG_STOP  = 4'd5,
		EV_DOUBLE     = 4'd6,
		EV_STUCK      = 4'd7,
		EV_FREE       = 4'd8
	} ev_t;

	typedef enum logic [2:0] {
		M_RELEASE   = 3'd0,
		M_SHORT     = 3'd1,
		M_LONG      = 3'd2,
		M_PREDOUBLE = 3'd3,
		M_DOUBLE    = 3'd4,
		M_STUCK     = 3'd5
	} mode_t;

	typedef enum logic [IDX_W-1:0] {
		REG_PRESS_DB   = 3'd0,
		REG_RELEASE_DB = 3'd1,
		REG_LONG       = 3'd2,
		REG_REPEAT     = 3'd3,
		REG_GAP        = 3'd4,
		REG_STUCK      = 3'd5,
		REG_ACTIVE_LOW = 3'd6,
		REG_FEATURES   = 3'd7
	} reg_idx_t;

	localparam logic [TH_W-1:0] RST_PRESS_DB   = 16'd2;
	localparam logic [TH_W-1:0] RST_RELEASE_DB = 16'd2;
	localparam logic [TH_W-1:0] RST_LONG       = 16'd50;
	localparam logic [TH_W-1:0] RST_REPEAT     = 16'd10;
	localparam logic [TH_W-1:0] RST_GAP        = 16'd20;
	localparam logic [TH_W-1:0] RST_STUCK      = 16'd2000;

	typedef struct packed {
		logic [TH_W-1:0] press_db;
		logic [TH_W-1:0] release_db;
		logic [TH_W-1:0] long_ticks;
		logic [TH_W-1:0] repeat_ticks;
		logic [TH_W-1:0] gap_ticks;
		logic [TH_W-1:0] stuck_ticks;
		logic            active_low;
		logic            dbl_en;
		logic            stuck_en;
	} cfg_t;

	// events caused by one tick: n is 0, 1 or 2
	typedef struct packed {
		logic [1:0] n;
		ev_t        ev0;
		ev_t        ev1;
	} evpair_t;

endpackage

FILE: design/bdpc_cfg.sv
// Configuration register file
module bdpc_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bdpc_pkg::IDX_W-1:0]     cfg_index,
	input  logic [bdpc_pkg::TH_W-1:0]      cfg_data,
	output bdpc_pkg::cfg_t                 cfg
);

	bdpc_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.press_db     <= bdpc_pkg::RST_PRESS_DB;
			cfg_q.release_db   <= bdpc_pkg::RST_RELEASE_DB;
			cfg_q.long_ticks   <= bdpc_pkg::RST_LONG;
			cfg_q.repeat_ticks <= bdpc_pkg::RST_REPEAT;
			cfg_q.gap_ticks    <= bdpc_pkg::RST_GAP;
			cfg_q.stuck_ticks  <= bdpc_pkg::RST_STUCK;
			cfg_q.active_low   <= 1'b0;
			cfg_q.dbl_en       <= 1'b0;
			cfg_q.stuck_en     <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (bdpc_pkg::reg_idx_t'(cfg_index))
				bdpc_pkg::REG_PRESS_DB:   cfg_q.press_db     <= cfg_data;
				bdpc_pkg::REG_RELEASE_DB: cfg_q.release_db   <= cfg_data;
				bdpc_pkg::REG_LONG:       cfg_q.long_ticks   <= cfg_data;
				bdpc_pkg::REG_REPEAT:     cfg_q.repeat_ticks <= cfg_data;
				bdpc_pkg::REG_GAP:        cfg_q.gap_ticks    <= cfg_data;
				bdpc_pkg::REG_STUCK:      cfg_q.stuck_ticks  <= cfg_data;
				bdpc_pkg::REG_ACTIVE_LOW: cfg_q.active_low   <= cfg_data[0];
				bdpc_pkg::REG_FEATURES: begin
					cfg_q.dbl_en   <= cfg_data[0];
					cfg_q.stuck_en <= cfg_data[1];
				end
				default: ;
			endcase
		end
	end

endmodule

FILE: design/bdpc_core.sv
// Debounce, tick counters and press mode machine; one tick per fire
module bdpc_core #(
	parameter int unsigned COUNTER_WIDTH = bdpc_pkg::COUNTER_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic              pin,
	input  bdpc_pkg::cfg_t    cfg,
	output bdpc_pkg::evpair_t evs
);

	localparam int unsigned CW    = COUNTER_WIDTH;
	localparam int unsigned CMP_W = (CW > bdpc_pkg::TH_W) ? CW : bdpc_pkg::TH_W;
	localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

	function automatic logic ge(input logic [CW-1:0] c, input logic [bdpc_pkg::TH_W-1:0] t);
		logic [CMP_W-1:0] a;
		logic [CMP_W-1:0] b;
		a = CMP_W'(c);
		b = CMP_W'(t);
		return a >= b;
	endfunction

	function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

	logic            db_q, db_d;
	logic [CW-1:0]   dcnt_q, dcnt_d;
	logic [CW-1:0]   ptk_q, ptk_d;
	logic [CW-1:0]   rtk_q, rtk_d;
	logic [CW-1:0]   rcnt_q, rcnt_d;
	bdpc_pkg::mode_t mode_q, mode_d;

	logic          raw;
	logic [CW-1:0] dcnt_inc;
	logic [CW-1:0] rcnt_inc;
	logic          long_hit, stuck_hit, gap_hit, rep_hit;
	logic          mode_pressed;

	assign raw      = (pin != cfg.active_low);
	assign dcnt_inc = sat_inc(dcnt_q);
	assign rcnt_inc = sat_inc(rcnt_q);

	// debounce and pressed/released time
	always_comb begin
		db_d   = db_q;
		dcnt_d = dcnt_q;
		ptk_d  = ptk_q;
		rtk_d  = rtk_q;
		if (!db_q) begin
			if (raw) begin
				dcnt_d = dcnt_inc;
				if (ge(dcnt_inc, cfg.press_db)) begin
					dcnt_d = '0;
					db_d   = 1'b1;
					ptk_d  = '0;
				end
			end else begin
				rtk_d  = sat_inc(rtk_q);
				dcnt_d = '0;
			end
		end else begin
			if (!raw) begin
				dcnt_d = dcnt_inc;
				if (ge(dcnt_inc, cfg.release_db)) begin
					dcnt_d = '0;
					db_d   = 1'b0;
					rtk_d  = '0;
				end
			end else begin
				ptk_d  = sat_inc(ptk_q);
				dcnt_d = '0;
			end
		end
	end

	assign long_hit  = ge(ptk_d, cfg.long_ticks);
	assign stuck_hit = cfg.stuck_en && ge(ptk_d, cfg.stuck_ticks);
	assign gap_hit   = ge(rtk_d, cfg.gap_ticks);
	assign rep_hit   = ge(rcnt_inc, cfg.repeat_ticks);

	// next mode and repeat counter
	always_comb begin
		mode_d = mode_q;
		rcnt_d = rcnt_q;
		case (mode_q)
			bdpc_pkg::M_RELEASE: begin
				if (db_d) mode_d = bdpc_pkg::M_SHORT;
			end
			bdpc_pkg::M_SHORT: begin
				if (!db_d) begin
					mode_d = cfg.dbl_en ? bdpc_pkg::M_PREDOUBLE : bdpc_pkg::M_RELEASE;
				end else if (long_hit) begin
					mode_d = bdpc_pkg::M_LONG;
					rcnt_d = '0;
				end
			end
			bdpc_pkg::M_LONG: begin
				if (!db_d) begin
					mode_d = bdpc_pkg::M_RELEASE;
				end else if (stuck_hit) begin
					mode_d = bdpc_pkg::M_STUCK;
				end else begin
					rcnt_d = rep_hit ? '0 : rcnt_inc;
				end
			end
			bdpc_pkg::M_PREDOUBLE: begin
				if (db_d) mode_d = bdpc_pkg::M_DOUBLE;
				else if (gap_hit) mode_d = bdpc_pkg::M_RELEASE;
			end
			bdpc_pkg::M_DOUBLE: begin
				if (!db_d) mode_d = bdpc_pkg::M_RELEASE;
				else if (stuck_hit) mode_d = bdpc_pkg::M_STUCK;
			end
			bdpc_pkg::M_STUCK: begin
				if (!db_d) mode_d = bdpc_pkg::M_RELEASE;
			end
			default: ;
		endcase
	end

	// events, in emission order
	always_comb begin
		evs.n   = 2'd0;
		evs.ev0 = bdpc_pkg::EV_PRESS;
		evs.ev1 = bdpc_pkg::EV_RELEASE;
		case (mode_q)
			bdpc_pkg::M_RELEASE: begin
				if (db_d) begin
					evs.n   = 2'd1;
					evs.ev0 = bdpc_pkg::EV_PRESS;
				end
			end
			bdpc_pkg::M_SHORT: begin
				if (!db_d) begin
					if (cfg.dbl_en) begin
						evs.n   = 2'd1;
						evs.ev0 = bdpc_pkg::EV_RELEASE;
					end else begin
						evs.n   = 2'd2;
						evs.ev0 = bdpc_pkg::EV_SHORT;
						evs.ev1 = bdpc_pkg::EV_RELEASE;
					end
				end else if (long_hit) begin
					evs.n   = 2'd1;
					evs.ev0 = bdpc_pkg::EV_LONG_START;
				end
			end
			bdpc_pkg::M_LONG: begin
				if (!db_d) begin
					evs.n   = 2'd2;
					evs.ev0 = bdpc_pkg::EV_LONG_STOP;
					evs.ev1 = bdpc_pkg::EV_RELEASE;
				end else if (stuck_hit) begin
					evs.n   = 2'd1;
					evs.ev0 = bdpc_pkg::EV_STUCK;
				end else if (rep_hit) begin
					evs.n   = 2'd1;
					evs.ev0 = bdpc_pkg::EV_REPEAT;
				end
			end
			bdpc_pkg::M_PREDOUBLE: begin
				if (db_d) begin
					evs.n   = 2'd2;
					evs.ev0 = bdpc_pkg::EV_DOUBLE;
					evs.ev1 = bdpc_pkg::EV_PRESS;
				end else if (gap_hit) begin
					evs.n   = 2'd1;
					evs.ev0 = bdpc_pkg::EV_SHORT;
				end
			end
			bdpc_pkg::M_DOUBLE: begin
				if (!db_d) begin
					evs.n   = 2'd1;
					evs.ev0 = bdpc_pkg::EV_RELEASE;
				end else if (stuck_hit) begin
					evs.n   = 2'd1;
					evs.ev0 = bdpc_pkg::EV_STUCK;
				end
			end
			bdpc_pkg::M_STUCK: begin
				if (!db_d) begin
					evs.n   = 2'd2;
					evs.ev0 = bdpc_pkg::EV_FREE;
					evs.ev1 = bdpc_pkg::EV_RELEASE;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			db_q   <= 1'b0;
			dcnt_q <= '0;
			ptk_q  <= '0;
			rtk_q  <= '0;
			rcnt_q <= '0;
			mode_q <= bdpc_pkg::M_RELEASE;
		end else if (fire) begin
			db_q   <= db_d;
			dcnt_q <= dcnt_d;
			ptk_q  <= ptk_d;
			rtk_q  <= rtk_d;
			rcnt_q <= rcnt_d;
			mode_q <= mode_d;
		end
	end

	assign mode_pressed = (mode_q == bdpc_pkg::M_SHORT) || (mode_q == bdpc_pkg::M_LONG) ||
		(mode_q == bdpc_pkg::M_DOUBLE) || (mode_q == bdpc_pkg::M_STUCK);

`include "button_debounce_press_classifier_assert.svh"

	`BDPC_ASSERT_NOW(a_mode_matches_level, 1'b1, mode_pressed == db_q, "mode disagrees with level")
	`BDPC_ASSERT_NEXT(a_level_holds_idle, !fire, $stable(db_q) && $stable(mode_q), "state moved without a tick")

endmodule

FILE: design/bdpc_outq.sv
// Two-deep queue of per-tick event pairs, drained one event per beat
module bdpc_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  bdpc_pkg::evpair_t din,
	output logic              full,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [3:0]        event_code,
	output logic              last_event
);

	bdpc_pkg::evpair_t ent_q [2];
	logic              wp_q, rp_q;
	logic [1:0]        cnt_q;
	logic              sel_q;
	bdpc_pkg::evpair_t head;
	logic              beat, pop;

	assign head       = ent_q[rp_q];
	assign full       = (cnt_q == 2'd2);
	assign out_valid  = (cnt_q != 2'd0);
	assign event_code = sel_q ? head.ev1 : head.ev0;
	assign last_event = sel_q || (head.n != 2'd2);
	assign beat       = out_valid && !out_stall;
	assign pop        = beat && last_event;

	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
			sel_q <= 1'b0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			if (beat) sel_q <= !last_event;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`include "button_debounce_press_classifier_assert.svh"

	`BDPC_ASSERT_NEXT(a_pair_completes, beat && !last_event, out_valid && last_event && sel_q, "second event of a pair missing")

endmodule

FILE: design/button_debounce_press_classifier.sv
// Push-button debounce and press classifier, top level
// Order: input register, then core into the event queue, whose head drives the event ports.
// Throughput: one tick per cycle unless the queue is full; a two-event tick gives two beats.
// Rate is set by the single-pass core between input register and a two-deep event queue.
// Reset (arst_n low, asynchronous): debounced released, counters zero, release mode,
// registers at defaults, queue empty.
module button_debounce_press_classifier #(
	parameter int unsigned COUNTER_WIDTH = bdpc_pkg::COUNTER_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       pin_level,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [3:0]                 event_code,
	output logic                       last_event,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [bdpc_pkg::IDX_W-1:0] cfg_index,
	input  logic [bdpc_pkg::TH_W-1:0]  cfg_data
);

	bdpc_pkg::cfg_t    cfg;
	bdpc_pkg::evpair_t evs;
	logic              v_s1, pin_s1;
	logic              full, fire, push;

	assign in_stall = v_s1 && full;
	assign fire     = v_s1 && !full;
	assign push     = fire && (evs.n != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!in_stall) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) pin_s1 <= pin_level;
	end

	bdpc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bdpc_core #(
		.COUNTER_WIDTH (COUNTER_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.pin    (pin_s1),
		.cfg    (cfg),
		.evs    (evs)
	);

	bdpc_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.din        (evs),
		.full       (full),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.event_code (event_code),
		.last_event (last_event)
	);

endmodule

FILE: tb/button_debounce_press_classifier_test.sv
// Self-checking testbench for the button debounce and press classifier
module button_debounce_press_classifier_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW          = bdpc_pkg::COUNTER_WIDTH_DEF;
	localparam int TW          = bdpc_pkg::TH_W;
	localparam int DRAIN       = 4;
	localparam int QUIET_LIMIT = 5000;
	localparam int SEG_TICKS   = 56;
	localparam int SOAK_TICKS  = 60;
	localparam int DIR_ROWS    = 36;

	// filler for event slots that carry nothing
	localparam bdpc_pkg::ev_t NO_EV = bdpc_pkg::EV_PRESS;

	typedef struct packed {
		bdpc_pkg::ev_t code;
		logic          last;
	} ev_beat_t;

	typedef enum logic [1:0] {
		ROW_TICK,
		ROW_TYPED,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t          kind;
		bdpc_pkg::reg_idx_t idx;
		logic [TW-1:0]      data;
		logic               pin;
		logic [1:0]         n;
		bdpc_pkg::ev_t      e0;
		bdpc_pkg::ev_t      e1;
	} dir_row_t;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic                       pin_level;
	logic                       out_valid;
	logic                       out_stall;
	logic [3:0]                 event_code;
	logic                       last_event;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [bdpc_pkg::IDX_W-1:0] cfg_index;
	logic [TW-1:0]              cfg_data;

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int bad_events    = 0;

	ev_beat_t pending_events[$];

	// shadow of the block: settings and classifier state
	bdpc_pkg::cfg_t  shadow;
	logic            btn_down;
	logic [CW-1:0]   settle_cnt;
	logic [CW-1:0]   held_ticks;
	logic [CW-1:0]   idle_ticks;
	logic [CW-1:0]   rpt_cnt;
	bdpc_pkg::mode_t press_state;

	// pressed level is low once active_low is set (from the twelfth row on)
	dir_row_t dir_tbl [0:DIR_ROWS-1] = '{
		'{ROW_TYPED, bdpc_pkg::REG_PRESS_DB, 16'd0, 1'b0, 2'd0, NO_EV, NO_EV},
		'{ROW_TYPED, bdpc_pkg::REG_PRESS_DB, 16'd0, 1'b1, 2'd0, NO_EV, NO_EV},
		'{ROW_TYPED, bdpc_pkg::REG_PRESS_DB, 16'd0, 1'b1, 2'd1, bdpc_pkg::EV_PRESS, NO_EV},
		'{ROW_TYPED, bdpc_pkg::REG_PRESS_DB, 16'd0, 1'b0, 2'd0, NO_EV, NO_EV},
		'{ROW_TYPED, bdpc_pkg::REG_PRESS_DB, 16'd0, 1'b0, 2'd2,
			bdpc_pkg::EV_SHORT, bdpc_pkg::EV_RELEASE},
		'{ROW_CFG, bdpc_pkg::REG_PRESS_DB, 16'd0, 1'b0, 2'd0, NO_EV, NO_EV},
		'{ROW_CFG, bdpc_pkg::REG_RELEASE_DB, 16'd0, 1'b0, 2'd0, NO_EV, NO_EV},
		'{ROW_CFG, bdpc_pkg::REG_LONG, 16'd2, 1'b0, 2'd0, NO_EV, NO_EV},
		'{ROW_CFG, bdpc_pkg::REG_REPEAT, 16'd0, 1'b0, 2'd0, NO_EV, NO_EV},
		'{ROW_CFG, bdpc_pkg::REG_GAP, 16'd1, 1'b0, 2'd0, NO_EV, NO_EV},
		'{ROW_CFG, bdpc_pkg::REG_STUCK, 16'd4, 1'b0, 2'd0, NO_EV, NO_EV},
		'{ROW_CFG, bdpc_pkg::REG_ACTIVE_LOW, 16'hFFFF, 1'b0, 2'd0, NO_EV, NO_EV},
		'{ROW_CFG, bdpc_pkg::REG_FEATURES, 16'hFFFF, 1'b0, 2'd0, NO_EV, NO_EV},
		'{ROW_TICK, bdpc_pkg::REG_PRESS_DB, 16'd0, 1'b0, 2'd0, NO_EV, NO_EV},
		'{ROW_TICK, bdpc_pkg::REG_PRESS_DB, 16'd0, 1'b0, 2'd0, NO_EV, NO_EV},
		'{ROW_TICK, bdpc_pkg::REG_PRESS_DB, 16'd0, 1'b0, 2'd0, NO_EV, NO_EV},
		'{ROW_TICK, bdpc_pkg::REG_PRESS_DB, 16'd0, 1'b0, 2'd0, NO_EV, NO_EV},
		'{ROW_TICK, bdpc_pkg::REG_PRESS_DB, 16'd0, 1'b0, 2'd0, NO_EV, NO_EV},
		'{ROW_TICK, bdpc_pkg::REG_PRESS_DB, 16'd0, 1'b1, 2'd0, NO_EV, NO_EV},
		'{ROW_TICK, bdpc_pkg::REG_PRESS_DB, 16'd0, 1'b0, 2'd0, NO_EV, NO_EV},
		'{ROW_TICK, bdpc_pkg::REG_PRESS_DB, 16'd0, 1'b1, 2'd0, NO_EV, NO_EV},
		// double-click off while waiting for the second press
		'{ROW_CFG, bdpc_pkg::REG_FEATURES, 16'h0002, 1'b0, 2'd0, NO_EV, NO_EV},
		'{ROW_TICK, bdpc_pkg::REG_PRESS_DB, 16'd0, 1'b0, 2'd0, NO_EV, NO_EV},
		'{ROW_TICK, bdpc_pkg::REG_PRESS_DB, 16'd0, 1'b0, 2'd0, NO_EV, NO_EV},
		'{ROW_TICK, bdpc_pkg::REG_PRESS_DB, 16'd0, 1'b0, 2'd0, NO_EV, NO_EV},
		'{ROW_TICK, bdpc_pkg::REG_PRESS_DB, 16'd0, 1'b0, 2'd0, NO_EV, NO_EV},
		'{ROW_TICK, bdpc_pkg::REG_PRESS_DB, 16'd0, 1'b0, 2'd0, NO_EV, NO_EV},
		'{ROW_TICK, bdpc_pkg::REG_PRESS_DB, 16'd0, 1'b1, 2'd0, NO_EV, NO_EV},
		'{ROW_CFG, bdpc_pkg::REG_FEATURES, 16'h0001, 1'b0, 2'd0, NO_EV, NO_EV},
		'{ROW_TICK, bdpc_pkg::REG_PRESS_DB, 16'd0, 1'b0, 2'd0, NO_EV, NO_EV},
		'{ROW_TICK, bdpc_pkg::REG_PRESS_DB, 16'd0, 1'b1, 2'd0, NO_EV, NO_EV},
		'{ROW_TICK, bdpc_pkg::REG_PRESS_DB, 16'd0, 1'b1, 2'd0, NO_EV, NO_EV},
		'{ROW_TICK, bdpc_pkg::REG_PRESS_DB, 16'd0, 1'b0, 2'd0, NO_EV, NO_EV},
		'{ROW_TICK, bdpc_pkg::REG_PRESS_DB, 16'd0, 1'b0, 2'd0, NO_EV, NO_EV},
		'{ROW_TICK, bdpc_pkg::REG_PRESS_DB, 16'd0, 1'b0, 2'd0, NO_EV, NO_EV},
		'{ROW_TICK, bdpc_pkg::REG_PRESS_DB, 16'd0, 1'b1, 2'd0, NO_EV, NO_EV}
	};

	button_debounce_press_classifier dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.pin_level  (pin_level),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.event_code (event_code),
		.last_event (last_event),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [CW-1:0] sat_up(input logic [CW-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// one tick through debounce and the mode machine; returns up to two events
	function automatic void classify_tick(input logic lvl, output logic [1:0] n,
			output bdpc_pkg::ev_t e0, output bdpc_pkg::ev_t e1);
		logic          raw;
		bdpc_pkg::ev_t evs [0:1];
		int            k;
		raw    = (lvl != shadow.active_low);
		evs[0] = NO_EV;
		evs[1] = NO_EV;
		k      = 0;
		if (!btn_down) begin
			if (raw) begin
				settle_cnt = sat_up(settle_cnt);
				if (settle_cnt >= shadow.press_db) begin
					settle_cnt = '0;
					btn_down   = 1'b1;
					held_ticks = '0;
				end
			end else begin
				idle_ticks = sat_up(idle_ticks);
				settle_cnt = '0;
			end
		end else begin
			if (!raw) begin
				settle_cnt = sat_up(settle_cnt);
				if (settle_cnt >= shadow.release_db) begin
					settle_cnt = '0;
					btn_down   = 1'b0;
					idle_ticks = '0;
				end
			end else begin
				held_ticks = sat_up(held_ticks);
				settle_cnt = '0;
			end
		end
		case (press_state)
			bdpc_pkg::M_RELEASE: begin
				if (btn_down) begin
					press_state = bdpc_pkg::M_SHORT;
					evs[k] = bdpc_pkg::EV_PRESS; k++;
				end
			end
			bdpc_pkg::M_SHORT: begin
				if (!btn_down) begin
					if (shadow.dbl_en) begin
						press_state = bdpc_pkg::M_PREDOUBLE;
					end else begin
						press_state = bdpc_pkg::M_RELEASE;
						evs[k] = bdpc_pkg::EV_SHORT; k++;
					end
					evs[k] = bdpc_pkg::EV_RELEASE; k++;
				end else if (held_ticks >= shadow.long_ticks) begin
					press_state = bdpc_pkg::M_LONG;
					rpt_cnt = '0;
					evs[k] = bdpc_pkg::EV_LONG_START; k++;
				end
			end
			bdpc_pkg::M_LONG: begin
				if (!btn_down) begin
					press_state = bdpc_pkg::M_RELEASE;
					evs[k] = bdpc_pkg::EV_LONG_STOP; k++;
					evs[k] = bdpc_pkg::EV_RELEASE; k++;
				end else if (shadow.stuck_en && held_ticks >= shadow.stuck_ticks) begin
					press_state = bdpc_pkg::M_STUCK;
					evs[k] = bdpc_pkg::EV_STUCK; k++;
				end else begin
					rpt_cnt = sat_up(rpt_cnt);
					if (rpt_cnt >= shadow.repeat_ticks) begin
						rpt_cnt = '0;
						evs[k] = bdpc_pkg::EV_REPEAT; k++;
					end
				end
			end
			bdpc_pkg::M_PREDOUBLE: begin
				if (!btn_down) begin
					if (idle_ticks >= shadow.gap_ticks) begin
						press_state = bdpc_pkg::M_RELEASE;
						evs[k] = bdpc_pkg::EV_SHORT; k++;
					end
				end else begin
					press_state = bdpc_pkg::M_DOUBLE;
					evs[k] = bdpc_pkg::EV_DOUBLE; k++;
					evs[k] = bdpc_pkg::EV_PRESS; k++;
				end
			end
			bdpc_pkg::M_DOUBLE: begin
				if (!btn_down) begin
					press_state = bdpc_pkg::M_RELEASE;
					evs[k] = bdpc_pkg::EV_RELEASE; k++;
				end else if (shadow.stuck_en && held_ticks >= shadow.stuck_ticks) begin
					press_state = bdpc_pkg::M_STUCK;
					evs[k] = bdpc_pkg::EV_STUCK; k++;
				end
			end
			bdpc_pkg::M_STUCK: begin
				if (!btn_down) begin
					press_state = bdpc_pkg::M_RELEASE;
					evs[k] = bdpc_pkg::EV_FREE; k++;
					evs[k] = bdpc_pkg::EV_RELEASE; k++;
				end
			end
			default: ;
		endcase
		n  = k[1:0];
		e0 = evs[0];
		e1 = evs[1];
	endfunction

	task automatic send_tick(input logic lvl, input bit typed, input logic [1:0] tn,
			input bdpc_pkg::ev_t te0, input bdpc_pkg::ev_t te1);
		logic [1:0]    pn;
		bdpc_pkg::ev_t pe0;
		bdpc_pkg::ev_t pe1;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		pin_level <= lvl;
		do @(posedge clk); while (in_stall);
		classify_tick(lvl, pn, pe0, pe1);
		if (typed) begin
			pn  = tn;
			pe0 = te0;
			pe1 = te1;
		end
		if (pn == 2'd1) begin
			pending_events.push_back(ev_beat_t'{pe0, 1'b1});
		end else if (pn == 2'd2) begin
			pending_events.push_back(ev_beat_t'{pe0, 1'b0});
			pending_events.push_back(ev_beat_t'{pe1, 1'b1});
		end
	endtask

	// block drained: every expected beat seen, then a drain wait for ticks that give no event
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(input bdpc_pkg::reg_idx_t idx, input logic [TW-1:0] data,
			input bit more);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			bdpc_pkg::REG_PRESS_DB:   shadow.press_db     = data;
			bdpc_pkg::REG_RELEASE_DB: shadow.release_db   = data;
			bdpc_pkg::REG_LONG:       shadow.long_ticks   = data;
			bdpc_pkg::REG_REPEAT:     shadow.repeat_ticks = data;
			bdpc_pkg::REG_GAP:        shadow.gap_ticks    = data;
			bdpc_pkg::REG_STUCK:      shadow.stuck_ticks  = data;
			bdpc_pkg::REG_ACTIVE_LOW: shadow.active_low   = data[0];
			bdpc_pkg::REG_FEATURES: begin
				shadow.dbl_en   = data[0];
				shadow.stuck_en = data[1];
			end
			default: ;
		endcase
		if (!more) cfg_valid <= 1'b0;
	endtask

	task automatic program_all(input bdpc_pkg::cfg_t c);
		logic [TW-1:0] junk;
		junk = TW'($urandom);
		write_reg(bdpc_pkg::REG_PRESS_DB, c.press_db, 1'b1);
		write_reg(bdpc_pkg::REG_RELEASE_DB, c.release_db, 1'b1);
		write_reg(bdpc_pkg::REG_LONG, c.long_ticks, 1'b1);
		write_reg(bdpc_pkg::REG_REPEAT, c.repeat_ticks, 1'b1);
		write_reg(bdpc_pkg::REG_GAP, c.gap_ticks, 1'b1);
		write_reg(bdpc_pkg::REG_STUCK, c.stuck_ticks, 1'b1);
		write_reg(bdpc_pkg::REG_ACTIVE_LOW, {junk[TW-1:1], c.active_low}, 1'b1);
		write_reg(bdpc_pkg::REG_FEATURES, {junk[TW-1:2], c.stuck_en, c.dbl_en}, 1'b0);
	endtask

	// press/release bursts with occasional bounce, plus stretches of chatter
	task automatic run_presses(input int n_items);
		int sent;
		int hold;
		int gap;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 9) < 2) begin
				hold = $urandom_range(1, 4);
				repeat (hold) send_tick(1'($urandom_range(0, 1)), 1'b0, 2'd0, NO_EV, NO_EV);
				sent += hold;
			end else begin
				hold = $urandom_range(0, 1) ? $urandom_range(1, 12) : $urandom_range(13, 90);
				gap  = $urandom_range(1, 30);
				repeat (hold)
					send_tick(shadow.active_low ^ 1'b1 ^ ($urandom_range(0, 19) == 0),
						1'b0, 2'd0, NO_EV, NO_EV);
				repeat (gap)
					send_tick(shadow.active_low ^ ($urandom_range(0, 19) == 0),
						1'b0, 2'd0, NO_EV, NO_EV);
				sent += hold + gap;
			end
		end
	endtask

	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	always @(posedge clk) begin : check_events
		ev_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_events.size() == 0) begin
				bad_events++;
				if (bad_events <= 10)
					$display("unexpected event: code=%0d last=%0b", event_code, last_event);
			end else begin
				want = pending_events.pop_front();
				if (event_code !== want.code || last_event !== want.last) begin
					bad_events++;
					if (bad_events <= 10)
						$display("event mismatch: expected code=%0d last=%0b, got code=%0d last=%0b",
							want.code, want.last, event_code, last_event);
				end
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		int             idle_tbl  [0:3];
		int             stall_tbl [0:3];
		bdpc_pkg::cfg_t c;
		dir_row_t       r;
		idle_tbl  = '{0, 70, 0, 17};
		stall_tbl = '{0, 0, 70, 17};
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		pin_level <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= bdpc_pkg::REG_PRESS_DB;
		cfg_data  <= '0;

		shadow.press_db     = bdpc_pkg::RST_PRESS_DB;
		shadow.release_db   = bdpc_pkg::RST_RELEASE_DB;
		shadow.long_ticks   = bdpc_pkg::RST_LONG;
		shadow.repeat_ticks = bdpc_pkg::RST_REPEAT;
		shadow.gap_ticks    = bdpc_pkg::RST_GAP;
		shadow.stuck_ticks  = bdpc_pkg::RST_STUCK;
		shadow.active_low   = 1'b0;
		shadow.dbl_en       = 1'b0;
		shadow.stuck_en     = 1'b0;
		btn_down    = 1'b0;
		settle_cnt  = '0;
		held_ticks  = '0;
		idle_ticks  = '0;
		rpt_cnt     = '0;
		press_state = bdpc_pkg::M_RELEASE;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			r = dir_tbl[i];
			if (r.kind == ROW_CFG) begin
				if (i == 0 || dir_tbl[i-1].kind != ROW_CFG) settle();
				write_reg(r.idx, r.data, (i + 1 < DIR_ROWS) && dir_tbl[i+1].kind == ROW_CFG);
			end else begin
				send_tick(r.pin, r.kind == ROW_TYPED, r.n, r.e0, r.e1);
			end
		end

		for (int p = 0; p < 4; p++) begin
			send_idle_pct = idle_tbl[p];
			stall_pct     = stall_tbl[p];
			for (int s = 0; s < 3; s++) begin
				settle();
				if (p == 0 && s == 0) begin
					c = '0;
					c.active_low = 1'($urandom_range(0, 1));
					c.dbl_en     = 1'b1;
					c.stuck_en   = 1'b1;
				end else if (p == 1 && s == 0) begin
					c = '1;
				end else begin
					c.press_db     = TW'($urandom_range(0, 4));
					c.release_db   = TW'($urandom_range(0, 4));
					c.long_ticks   = TW'($urandom_range(0, 40));
					c.repeat_ticks = TW'($urandom_range(0, 8));
					c.gap_ticks    = TW'($urandom_range(0, 25));
					c.stuck_ticks  = TW'($urandom_range(0, 80));
					c.active_low   = 1'($urandom_range(0, 1));
					c.dbl_en       = 1'($urandom_range(0, 1));
					c.stuck_en     = 1'($urandom_range(0, 1));
				end
				program_all(c);
				run_presses(SEG_TICKS);
			end
			if (p == 0) begin
				// long hold with stuck detection off, then turn it on mid-press
				settle();
				c = '0;
				c.press_db     = 16'd1;
				c.release_db   = 16'd1;
				c.long_ticks   = 16'd3;
				c.repeat_ticks = 16'hFFFF;
				c.gap_ticks    = 16'd5;
				c.stuck_ticks  = 16'd50;
				program_all(c);
				repeat (40) send_tick(1'b0, 1'b0, 2'd0, NO_EV, NO_EV);
				repeat (SOAK_TICKS) send_tick(1'b1, 1'b0, 2'd0, NO_EV, NO_EV);
				settle();
				write_reg(bdpc_pkg::REG_FEATURES, 16'h0002, 1'b0);
				repeat (2) send_tick(1'b1, 1'b0, 2'd0, NO_EV, NO_EV);
				repeat (3) send_tick(1'b0, 1'b0, 2'd0, NO_EV, NO_EV);
			end
		end

		settle();
		if (bad_events == 0 && pending_events.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
